/* rtl/dmfc_pkg.sv */
// dmfc_pkg: status, action and motor codes, register indexes and divider
// request/response types for the drip monitor. No dependencies.
package dmfc_pkg;
	localparam logic [2:0] ST_NOT_STARTED = 3'd0;
	localparam logic [2:0] ST_STARTED     = 3'd1;
	localparam logic [2:0] ST_IN_PROGRESS = 3'd2;
	localparam logic [2:0] ST_PAUSED      = 3'd3;
	localparam logic [2:0] ST_STOPPED     = 3'd4;
	localparam logic [2:0] ST_COMPLETED   = 3'd5;
	localparam logic [2:0] ST_EXCEEDED    = 3'd6;
	localparam logic [2:0] ST_OUT_FLUID   = 3'd7;

	localparam logic [1:0] ACT_TICK   = 2'd0;
	localparam logic [1:0] ACT_START  = 2'd1;
	localparam logic [1:0] ACT_PAUSE  = 2'd2;
	localparam logic [1:0] ACT_RESUME = 2'd3;

	localparam logic [1:0] CMD_OFF  = 2'd0;
	localparam logic [1:0] CMD_UP   = 2'd1;
	localparam logic [1:0] CMD_DOWN = 2'd2;
	localparam logic [1:0] CMD_KEEP = 2'd3;

	localparam logic [2:0] REG_TARGET_RATE  = 3'd0;
	localparam logic [2:0] REG_TARGET_DROPS = 3'd1;
	localparam logic [2:0] REG_DROP_FACTOR  = 3'd2;
	localparam logic [2:0] REG_DEBOUNCE     = 3'd3;
	localparam logic [2:0] REG_NO_DROP      = 3'd4;
	localparam logic [2:0] REG_OUT_FLUID    = 3'd5;
	localparam logic [2:0] REG_ALLOW        = 3'd6;

	localparam logic [23:0] MASK24   = 24'hFFFFFF;
	localparam logic [12:0] RATE_MAX = 13'd6000;
	localparam int          DIV_W    = 32;

	typedef struct packed {
		logic        start;
		logic [31:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] quo;
		logic [31:0] rem;
	} div_rsp_t;
endpackage

/* rtl/dmfc_div.sv */
// dmfc_div: shared restoring divider, one quotient bit per cycle.
// Depends on dmfc_pkg.
module dmfc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  dmfc_pkg::div_req_t req,
	output dmfc_pkg::div_rsp_t rsp
);
	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;
endmodule

/* rtl/drip_monitor_and_flow_control_top.sv */
// Drip monitor and flow control top: sequencer, infusion state and outputs.
// Depends on dmfc_pkg and dmfc_div.
//
// Each input beat is one millisecond tick, and only one tick is in work at a time.
// A tick uses one shared bit-serial divider for up to three divisions: the drip
// rate when a drop is taken with a nonzero gap, the volume when the drop factor
// is counted, and the on time when a new control window opens; elapsed seconds
// come from a combinational reciprocal multiply. The result beat sits in an
// output register, and the next tick is taken once that register is free or
// being emptied.
module drip_monitor_and_flow_control_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic        sensor_level,
	input  logic        upper_limit_hit,
	input  logic        homing_settled,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  infusion_status,
	output logic [12:0] drip_rate_out,
	output logic [23:0] drops_counted,
	output logic [23:0] volume_centi_ml,
	output logic [23:0] elapsed_seconds,
	output logic [1:0]  motor_command,
	output logic        homing_request
);
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_PRE    = 4'd1;
	localparam logic [3:0] S_LAUNCH = 4'd2;
	localparam logic [3:0] S_RATE   = 4'd3;
	localparam logic [3:0] S_VOL    = 4'd4;
	localparam logic [3:0] S_POST   = 4'd5;
	localparam logic [3:0] S_ELAP   = 4'd6;
	localparam logic [3:0] S_REG    = 4'd7;
	localparam logic [3:0] S_ONT    = 4'd8;

	localparam logic [23:0] MASK24_C   = dmfc_pkg::MASK24;
	localparam logic [12:0] RATE_MAX_C = dmfc_pkg::RATE_MAX;
	// ceil(2^38 / 1000): (x * SEC_RECIP) >> 38 is x / 1000 for any 32-bit x
	localparam logic [31:0] SEC_RECIP  = 32'h1062_4DD3;

	logic [12:0] tgt_rate_q;
	logic [23:0] tgt_drops_q;
	logic [7:0]  factor_q;
	logic [7:0]  debounce_q;
	logic [15:0] no_drop_q;
	logic [15:0] oof_q;
	logic [5:0]  allow_q;

	logic [3:0]  state_q;
	logic [1:0]  act_q;
	logic        lvl_q, top_q, set_q;
	logic        drop_q;
	logic        win_q;
	logic [31:0] gap_q;

	logic [31:0] ms_q, last_edge_q, last_drop_q, start_q, quiet_q, win_start_q, press_q;
	logic        prev_q, first_q, auto_q, homing_q, press_valid_q;
	logic [2:0]  status_q;
	logic [23:0] total_q, vol_q, elapsed_q;
	logic [7:0]  vrem_q;
	logic [12:0] rate_q, peak_q;
	logic [15:0] on_q;
	logic [1:0]  cmd_q;
	logic        ovalid_q;

	dmfc_pkg::div_req_t dreq;
	dmfc_pkg::div_rsp_t drsp;

	dmfc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign in_ready = (state_q == S_IDLE) && (!ovalid_q || out_ready);

	// combinational views of working state
	logic        counted;
	logic [13:0] diff;
	logic [13:0] hi_bound;
	logic [12:0] lo_bound;
	logic [31:0] now_win;
	logic [31:0] el_span;
	logic [63:0] el_prod;

	assign counted = (factor_q == 8'd10) || (factor_q == 8'd15) || (factor_q == 8'd20) ||
		(factor_q == 8'd60) || (factor_q == 8'd100);
	assign diff = (rate_q > tgt_rate_q) ? {1'b0, rate_q - tgt_rate_q}
		: {1'b0, tgt_rate_q - rate_q};
	assign hi_bound = {1'b0, tgt_rate_q} + {8'd0, allow_q};
	assign lo_bound = (tgt_rate_q > {7'd0, allow_q}) ? tgt_rate_q - {7'd0, allow_q} : 13'd0;
	assign now_win = ms_q - win_start_q;
	assign el_span = ms_q - start_q;
	assign el_prod = {32'd0, el_span} * {32'd0, SEC_RECIP};

	always_comb begin
		dreq.start = 1'b0;
		dreq.num   = '0;
		dreq.den   = 32'd1;
		unique case (state_q)
			S_LAUNCH: begin
				dreq.start = drop_q && (gap_q != 32'd0);
				dreq.num   = 32'd60000;
				dreq.den   = gap_q;
			end
			S_RATE: begin
				dreq.start = drop_q && counted && (drsp.done || (gap_q == 32'd0));
				dreq.num   = 32'd100 + {24'd0, vrem_q};
				dreq.den   = {24'd0, factor_q};
			end
			S_REG: begin
				dreq.start = win_q;
				dreq.num   = {18'd0, diff} * 32'd200;
				dreq.den   = (peak_q == 13'd0) ? 32'd1 : {19'd0, peak_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_rate_q  <= '0;
			tgt_drops_q <= MASK24_C;
			factor_q    <= 8'd255;
			debounce_q  <= 8'd10;
			no_drop_q   <= 16'd20000;
			oof_q       <= 16'd28000;
			allow_q     <= 6'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dmfc_pkg::REG_TARGET_RATE:  tgt_rate_q  <= cfg_data[12:0];
				dmfc_pkg::REG_TARGET_DROPS: tgt_drops_q <= cfg_data;
				dmfc_pkg::REG_DROP_FACTOR:  factor_q    <= cfg_data[7:0];
				dmfc_pkg::REG_DEBOUNCE:     debounce_q  <= cfg_data[7:0];
				dmfc_pkg::REG_NO_DROP:      no_drop_q   <= cfg_data[15:0];
				dmfc_pkg::REG_OUT_FLUID:    oof_q       <= cfg_data[15:0];
				dmfc_pkg::REG_ALLOW:        allow_q     <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		logic [2:0]  st;
		logic        au, hf, fd, pv, dp;
		logic [23:0] tot, vo, el;
		logic [7:0]  vr;
		logic [31:0] sm, gp;
		logic        restart, allowed;
		if (!arst_n) begin
			state_q <= S_IDLE;
			ms_q <= '0; last_edge_q <= '0; last_drop_q <= '0; start_q <= '0;
			quiet_q <= '0; win_start_q <= '0; press_q <= '0;
			prev_q <= 1'b0; first_q <= 1'b0; auto_q <= 1'b0; homing_q <= 1'b1;
			press_valid_q <= 1'b0; status_q <= dmfc_pkg::ST_NOT_STARTED;
			total_q <= '0; vol_q <= '0; elapsed_q <= '0; vrem_q <= '0;
			rate_q <= '0; peak_q <= 13'd1; on_q <= '0; cmd_q <= dmfc_pkg::CMD_KEEP;
			ovalid_q <= 1'b0; drop_q <= 1'b0; win_q <= 1'b0; gap_q <= '0;
			act_q <= '0; lvl_q <= 1'b0; top_q <= 1'b0; set_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					act_q <= action; lvl_q <= sensor_level;
					top_q <= upper_limit_hit; set_q <= homing_settled;
					state_q <= S_PRE;
				end
				S_PRE: begin
					st = status_q; au = auto_q; hf = homing_q; fd = first_q;
					tot = total_q; vo = vol_q; vr = vrem_q; el = elapsed_q;
					sm = start_q; pv = press_valid_q;
					if (set_q) hf = 1'b0;
					restart = 1'b0;
					if (act_q == dmfc_pkg::ACT_START) begin
						restart = 1'b1; st = dmfc_pkg::ST_IN_PROGRESS; au = 1'b1; fd = 1'b0;
					end else if (act_q != dmfc_pkg::ACT_TICK && !hf && tgt_rate_q != 13'd0
						&& tgt_drops_q != MASK24_C) begin
						allowed = 1'b0;
						if (act_q == dmfc_pkg::ACT_PAUSE) begin
							if (au) begin
								st = dmfc_pkg::ST_PAUSED; au = 1'b0; allowed = 1'b1;
							end
						end else if (!au) begin
							if (st == dmfc_pkg::ST_NOT_STARTED || st == dmfc_pkg::ST_STARTED ||
								st == dmfc_pkg::ST_COMPLETED || st == dmfc_pkg::ST_EXCEEDED ||
								st == dmfc_pkg::ST_OUT_FLUID) begin
								restart = 1'b1; fd = 1'b0;
							end
							st = dmfc_pkg::ST_IN_PROGRESS; au = 1'b1; allowed = 1'b1;
						end
						if (allowed) begin
							if (pv && (ms_q - press_q) < 32'd500 &&
								(st == dmfc_pkg::ST_IN_PROGRESS || st == dmfc_pkg::ST_PAUSED)) begin
								hf = 1'b1; au = 1'b0; st = dmfc_pkg::ST_COMPLETED;
							end
							press_q <= ms_q; pv = 1'b1;
						end
					end
					if (restart) begin
						el = '0; sm = ms_q; tot = '0; vo = '0; vr = '0;
					end
					dp = 1'b0;
					gp = ms_q - last_drop_q;
					if (lvl_q != prev_q) begin
						prev_q <= lvl_q;
						if (lvl_q) begin
							if ((ms_q - last_edge_q) >= {24'd0, debounce_q}) begin
								dp = 1'b1;
								last_edge_q <= ms_q;
								if (!fd) begin
									fd = 1'b1;
									gp = ms_q + 32'd9999;
									if (st != dmfc_pkg::ST_PAUSED) begin
										if (st != dmfc_pkg::ST_STOPPED) begin
											sm = ms_q; vo = '0; vr = '0;
										end else st = dmfc_pkg::ST_IN_PROGRESS;
									end
								end
								if (st == dmfc_pkg::ST_NOT_STARTED) st = dmfc_pkg::ST_STARTED;
								last_drop_q <= ms_q;
								if (tot != MASK24_C) tot = tot + 24'd1;
								if (gp == 32'd0) rate_q <= RATE_MAX_C;
							end
						end else quiet_q <= ms_q;
					end
					drop_q <= dp;
					gap_q <= gp;
					status_q <= st; auto_q <= au; homing_q <= hf; first_q <= fd;
					total_q <= tot; vol_q <= vo; vrem_q <= vr; elapsed_q <= el;
					start_q <= sm; press_valid_q <= pv;
					state_q <= S_LAUNCH;
				end
				S_LAUNCH: state_q <= S_RATE;
				S_RATE: begin
					// wait for the rate quotient (or skip with no drop / zero gap)
					if (!drop_q) state_q <= S_POST;
					else if (gap_q == 32'd0) begin
						if (counted) state_q <= S_VOL; else state_q <= S_POST;
					end else if (drsp.done) begin
						rate_q <= (drsp.quo > 32'd6000) ? RATE_MAX_C : drsp.quo[12:0];
						if (counted) state_q <= S_VOL; else state_q <= S_POST;
					end
				end
				S_VOL: begin
					if (!drsp.busy && !dreq.start && drsp.done) begin
						gp = {8'd0, vol_q} + drsp.quo;
						vol_q  <= (gp > {8'd0, MASK24_C}) ? MASK24_C : gp[23:0];
						vrem_q <= drsp.rem[7:0];
						state_q <= S_POST;
					end
				end
				S_POST: begin
					// drop bookkeeping tail, quiet watch, elapsed flag
					st = status_q; au = auto_q; hf = homing_q; fd = first_q;
					tot = total_q; vo = vol_q; vr = vrem_q; el = elapsed_q; sm = start_q;
					if (drop_q) begin
						if (tgt_drops_q != MASK24_C && tot >= tgt_drops_q &&
							{1'b0, tot} <= {1'b0, tgt_drops_q} + 25'd1) begin
							st = dmfc_pkg::ST_COMPLETED; au = 1'b0; hf = 1'b1;
						end else if (st == dmfc_pkg::ST_COMPLETED && set_q && !hf)
							st = dmfc_pkg::ST_EXCEEDED;
						if (rate_q > peak_q) peak_q <= rate_q;
					end
					if (!prev_q && fd) begin
						if ((ms_q - quiet_q) >= {16'd0, no_drop_q}) begin
							fd = 1'b0; rate_q <= '0;
							if (st == dmfc_pkg::ST_COMPLETED || st == dmfc_pkg::ST_EXCEEDED ||
								st == dmfc_pkg::ST_STARTED) begin
								st = dmfc_pkg::ST_NOT_STARTED;
								el = '0; sm = ms_q; tot = '0; vo = '0; vr = '0;
							end
							if (st == dmfc_pkg::ST_IN_PROGRESS) st = dmfc_pkg::ST_STOPPED;
						end
					end else if (st == dmfc_pkg::ST_STOPPED) begin
						if (top_q && (ms_q - quiet_q) >= {16'd0, oof_q}) begin
							quiet_q <= ms_q; hf = 1'b1; au = 1'b0; st = dmfc_pkg::ST_OUT_FLUID;
						end
					end else quiet_q <= ms_q;
					drop_q <= st != dmfc_pkg::ST_COMPLETED && st != dmfc_pkg::ST_OUT_FLUID && fd;
					status_q <= st; auto_q <= au; homing_q <= hf; first_q <= fd;
					total_q <= tot; vol_q <= vo; vrem_q <= vr; elapsed_q <= el; start_q <= sm;
					state_q <= S_ELAP;
				end
				S_ELAP: begin
					if (drop_q) elapsed_q <= el_prod[61:38];
					state_q <= S_REG;
					win_q <= now_win >= ((diff <= 14'd10) ? 32'd1000 : 32'd500);
					if (auto_q && (first_q ? (now_win <= {16'd0, on_q}) : 1'b1)
						&& tgt_rate_q != 13'd0) begin
						if (rate_q < lo_bound)
							cmd_q <= top_q ? dmfc_pkg::CMD_OFF : dmfc_pkg::CMD_UP;
						else if ({1'b0, rate_q} > hi_bound) cmd_q <= dmfc_pkg::CMD_DOWN;
						else cmd_q <= dmfc_pkg::CMD_OFF;
					end else if (auto_q) cmd_q <= dmfc_pkg::CMD_OFF;
					else cmd_q <= dmfc_pkg::CMD_KEEP;
				end
				S_REG: begin
					if (win_q) begin
						win_start_q <= ms_q;
						state_q <= S_ONT;
					end else begin
						ms_q <= ms_q + 32'd1; ovalid_q <= 1'b1; state_q <= S_IDLE;
					end
				end
				S_ONT: if (drsp.done) begin
					on_q <= (drsp.quo < 32'd30) ? 16'd30
						: (drsp.quo > 32'hFFFF) ? 16'hFFFF : drsp.quo[15:0];
					ms_q <= ms_q + 32'd1; ovalid_q <= 1'b1; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = ovalid_q;
	assign infusion_status = status_q;
	assign drip_rate_out   = rate_q;
	assign drops_counted   = total_q;
	assign volume_centi_ml = vol_q;
	assign elapsed_seconds = elapsed_q;
	assign motor_command   = cmd_q;
	assign homing_request  = homing_q;
endmodule

/* rtl/dmfc_checker.sv */
// dmfc_checker: port-level assertions for the drip monitor, bound to the top.
// Depends on drip_monitor_and_flow_control_top ports only.
module dmfc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [12:0] drip_rate_out,
	input logic [1:0]  motor_command
);
	a_rate_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drip_rate_out <= 13'd6000) else $error("rate over max");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("accepted while busy");
	a_no_out_next: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid) else $error("result too early");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(motor_command))
		else $error("result dropped");
endmodule

bind drip_monitor_and_flow_control_top dmfc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready),
	.drip_rate_out(drip_rate_out), .motor_command(motor_command)
);
